@@ sv/wide_symbol_compactor_macros.svh @@
// assertion macros for the asserting file wide_symbol_compactor.sv
`ifndef WIDE_SYMBOL_COMPACTOR_MACROS_SVH
`define WIDE_SYMBOL_COMPACTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define WSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wide_symbol_compactor assertion failed");

// next-cycle implication, checked out of reset
`define WSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wide_symbol_compactor assertion failed");

`endif

@@ sv/wsc_pkg.sv @@
`timescale 1ns / 1ps

package wsc_pkg;

    localparam int SLOTS  = 129;
    localparam int SYM_W  = 16;
    localparam int CODE_W = 8;
    localparam int LIM_W  = 7;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd126;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch accepted request, apply window start
        logic classify;  // decide literal / failed / empty table
        logic scan;      // step the slot search
        logic commit;    // write result, allocate or mark exhausted
        logic cfg_wr;    // write literal limit
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic direct;    // no search needed
        logic match;     // slot under compare holds the symbol
        logic last;      // last allocated slot under compare
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

@@ sv/wsc_ctrl.sv @@
`timescale 1ns / 1ps

module wsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  wsc_pkg::t_sts  i_sts,
    output wsc_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_CLASSIFY = 2'd1;
    localparam logic [1:0] S_SCAN     = 2'd2;
    localparam logic [1:0] S_FINISH   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cfg_ready  = 1'b1;
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                o_cmd.classify = 1'b1;
                n_state = i_sts.direct ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.match || i_sts.last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/wsc_dpath.sv @@
`timescale 1ns / 1ps

module wsc_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wsc_pkg::t_cmd                i_cmd,
    output wsc_pkg::t_sts                o_sts,
    input  logic [wsc_pkg::SYM_W-1:0]    i_wide_symbol,
    input  logic                         i_window_start,
    input  logic [wsc_pkg::LIM_W-1:0]    i_literal_limit,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [wsc_pkg::CODE_W-1:0]   o_narrow_code,
    output logic                         o_new_slot,
    output logic                         o_failed
);

    localparam logic [1:0] K_LIT  = 2'd0;
    localparam logic [1:0] K_HIT  = 2'd1;
    localparam logic [1:0] K_MISS = 2'd2;
    localparam logic [1:0] K_FAIL = 2'd3;

    localparam logic [wsc_pkg::CNT_W-1:0] SLOT_COUNT = wsc_pkg::CNT_W'(wsc_pkg::SLOTS);

    // slot table, written once per allocation, read at most once per scan step
    logic [wsc_pkg::SYM_W-1:0]  r_slot_mem [wsc_pkg::SLOTS];

    logic [wsc_pkg::SYM_W-1:0]  r_sym;
    logic [wsc_pkg::LIM_W-1:0]  r_limit;
    logic [wsc_pkg::CNT_W-1:0]  r_used;
    logic                       r_exh;
    logic [wsc_pkg::CNT_W-1:0]  r_rd_idx;
    logic [wsc_pkg::CNT_W-1:0]  r_cmp_idx;
    logic                       r_cmp_vld;
    logic [wsc_pkg::SYM_W-1:0]  r_rd_data;
    logic [1:0]                 r_kind;
    logic [wsc_pkg::CNT_W-1:0]  r_hit_idx;
    logic                       r_out_valid;
    logic [wsc_pkg::CODE_W-1:0] r_code;
    logic                       r_new;
    logic                       r_fail;

    logic                       lit;
    logic                       rd_en;
    logic [wsc_pkg::CODE_W-1:0] code_base;
    logic [wsc_pkg::CODE_W-1:0] n_code;
    logic                       n_new;
    logic                       n_fail;
    logic                       alloc_wr;
    logic                       set_exh;

    assign lit   = r_sym <= {{(wsc_pkg::SYM_W - wsc_pkg::LIM_W){1'b0}}, r_limit};
    assign rd_en = i_cmd.scan && (r_rd_idx < r_used);
    assign code_base = {1'b0, r_limit} + 8'd1;

    assign o_sts.direct   = r_exh || lit || (r_used == '0);
    assign o_sts.match    = r_cmp_vld && (r_rd_data == r_sym);
    assign o_sts.last     = r_cmp_vld && (r_cmp_idx == r_used - 1'b1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // result of the finished request
    always_comb begin
        n_code   = '0;
        n_new    = 1'b0;
        n_fail   = 1'b0;
        alloc_wr = 1'b0;
        set_exh  = 1'b0;
        case (r_kind)
            K_LIT: begin
                n_code = r_sym[wsc_pkg::CODE_W-1:0];
            end
            K_HIT: begin
                n_code = code_base + r_hit_idx;
            end
            K_MISS: begin
                if (r_used < SLOT_COUNT) begin
                    n_code   = code_base + r_used;
                    n_new    = 1'b1;
                    alloc_wr = i_cmd.commit;
                end else begin
                    n_fail  = 1'b1;
                    set_exh = i_cmd.commit;
                end
            end
            default: begin
                n_fail = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (alloc_wr) begin
            r_slot_mem[r_used[wsc_pkg::IDX_W-1:0]] <= r_sym;
        end
        if (rd_en) begin
            r_rd_data <= r_slot_mem[r_rd_idx[wsc_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= wsc_pkg::LIMIT_RESET;
            r_used      <= '0;
            r_exh       <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_limit <= i_literal_limit;
            end
            if (i_cmd.load && i_window_start) begin
                r_used <= '0;
                r_exh  <= 1'b0;
            end else if (alloc_wr) begin
                r_used <= r_used + 1'b1;
            end else if (set_exh) begin
                r_exh <= 1'b1;
            end
            if (i_cmd.classify) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_en;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= i_wide_symbol;
        end
        if (i_cmd.classify) begin
            r_rd_idx <= '0;
            r_kind   <= r_exh ? K_FAIL : (lit ? K_LIT : K_MISS);
        end
        if (rd_en) begin
            r_rd_idx  <= r_rd_idx + 1'b1;
            r_cmp_idx <= r_rd_idx;
        end
        if (i_cmd.scan && o_sts.match) begin
            r_kind    <= K_HIT;
            r_hit_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) begin
            r_code <= n_code;
            r_new  <= n_new;
            r_fail <= n_fail;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_narrow_code = r_code;
    assign o_new_slot    = r_new;
    assign o_failed      = r_fail;

endmodule

@@ sv/wide_symbol_compactor.sv @@
`timescale 1ns / 1ps
`include "wide_symbol_compactor_macros.svh"

// channel   direction  handshake                  payload
// in        request    i_in_valid / o_in_ready    i_wide_symbol, i_window_start
// out       result     o_out_valid / i_out_ready  o_narrow_code, o_new_slot, o_failed
// cfg       write      i_cfg_valid / o_cfg_ready  i_literal_limit
//
// a literal, an exhausted window or an empty slot table needs no slot search
// a wide symbol is searched one slot per cycle through the slot memory read port,
//   up to all 129 slots when every slot is allocated
// one request at a time; a new request is taken while the last result still waits
// reset (synchronous, active low) clears slot count and exhausted flag, sets limit to 126
// a stalled output holds the finished request in the finish step until taken

module wide_symbol_compactor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [wsc_pkg::SYM_W-1:0]     i_wide_symbol,
    input  logic                          i_window_start,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wsc_pkg::CODE_W-1:0]    o_narrow_code,
    output logic                          o_new_slot,
    output logic                          o_failed,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wsc_pkg::LIM_W-1:0]     i_literal_limit
);

    // command and status between sequencer and datapath
    wsc_pkg::t_cmd cmd;
    wsc_pkg::t_sts sts;

    // result payload with no code and no allocation
    logic          out_clear;

    assign out_clear = (o_narrow_code == '0) && !o_new_slot;

    // sequencer: idle, classify, slot scan, finish
    wsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // slot memory, counters and output register
    wsc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_wide_symbol   (i_wide_symbol),
        .i_window_start  (i_window_start),
        .i_literal_limit (i_literal_limit),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_narrow_code   (o_narrow_code),
        .o_new_slot      (o_new_slot),
        .o_failed        (o_failed)
    );

    // a failed result carries no code and no allocation
    `WSC_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, o_out_valid && o_failed, out_clear)
    // an accepted request keeps the input closed on the next cycle
    `WSC_ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, cmd.load, !o_in_ready)
    // a result is only written when the output register is free
    `WSC_ASSERT_NOW(a_commit_free, i_clk, i_rst_n, cmd.commit, sts.out_free)

endmodule
